// File: hw/rtl/spr_dma_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// spr_dma_pkg
// shared types and constants of the sprite dma channel sequencer
// ---------------------------------------------------------------------------
package spr_dma_pkg;

   localparam int CHANNELS = 8;
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic [2:0] OP_PTR_HI = 3'd0;
   localparam logic [2:0] OP_PTR_LO = 3'd1;
   localparam logic [2:0] OP_FRAME  = 3'd2;
   localparam logic [2:0] OP_SLOT_A = 3'd3;
   localparam logic [2:0] OP_SLOT_B = 3'd4;

   localparam logic [31:0] PTR_STEP = 32'd2;

   // one channel's context
   typedef struct packed {
      logic [31:0] list_base;
      logic [31:0] fetch_ptr;
      logic        armed;
      logic        terminated;
      logic        ctrl_next;
      logic [8:0]  start_line;
      logic [8:0]  stop_line;
      logic [15:0] first_word;
   } chan_state_type;

   // update toward the channel file
   typedef struct packed {
      logic           wr;
      logic           frame;
      chan_state_type st;
   } chan_upd_type;

   // one result transfer
   typedef struct packed {
      logic        pair_valid;
      logic [15:0] word0;
      logic [15:0] word1;
      logic        is_control;
      logic        mem_read;
      logic [31:0] read_addr;
   } rsp_type;

endpackage
`default_nettype wire

// File: hw/rtl/sprite_dma_channel_sequencer.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sprite_dma_channel_sequencer
// eight-channel sprite dma sequencer: pointer writes, frame restart, a/b slots
// ---------------------------------------------------------------------------
// a request passes the input register, then the result register, before its result is offered
// one transfer per cycle without rsp_stall; context read and decode are combinational
// the channel context is updated at the same edge that registers the result
// reset: synchronous, clears both pipeline valid flags and all channel contexts
// (pointers, lines and first word to zero, control fetch pending)
module sprite_dma_channel_sequencer (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [2:0]  req_operation,
   input  wire  [2:0]  req_channel,
   input  wire  [15:0] req_vpos,
   input  wire  [15:0] req_write_value,
   input  wire  [15:0] req_mem_word,
   // result channel
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_pair_valid,
   output logic [15:0] rsp_word0,
   output logic [15:0] rsp_word1,
   output logic        rsp_is_control,
   output logic        rsp_mem_read,
   output logic [31:0] rsp_read_addr
);
   import spr_dma_pkg::*;

   // input register
   logic        in_vld_ff, in_vld_in;
   logic [2:0]  in_op_ff;
   logic [2:0]  in_chan_ff;
   logic [15:0] in_vpos_ff;
   logic [15:0] in_wval_ff;
   logic [15:0] in_mword_ff;

   // result register
   logic        out_vld_ff, out_vld_in;
   rsp_type     out_ff, out_in;

   chan_state_type cur_state;
   chan_upd_type   upd;
   rsp_type        upd_rsp;
   logic           adv;
   logic           req_take;

   // the working item moves on when the result register is free or drains now
   assign adv       = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !adv;
   assign req_take  = req_valid && !req_stall;

   assign in_vld_in  = req_take || (in_vld_ff && !adv);
   assign out_vld_in = adv || (out_vld_ff && rsp_stall);
   assign out_in     = adv ? upd_rsp : out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff    <= req_operation;
         in_chan_ff  <= req_channel;
         in_vpos_ff  <= req_vpos;
         in_wval_ff  <= req_write_value;
         in_mword_ff <= req_mem_word;
      end
      out_ff <= out_in;
   end

   // per-channel context
   spr_dma_chan_file u_chan_file (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (in_chan_ff[CH_IDX_W-1:0]),
      .rd_state (cur_state),
      .upd_en   (adv),
      .upd      (upd)
   );

   // operation decode and slot decisions
   spr_dma_slot u_slot (
      .operation   (in_op_ff),
      .channel     (in_chan_ff),
      .vpos        (in_vpos_ff),
      .write_value (in_wval_ff),
      .mem_word    (in_mword_ff),
      .cur         (cur_state),
      .upd         (upd),
      .rsp         (upd_rsp)
   );

   assign rsp_valid      = out_vld_ff;
   assign rsp_pair_valid = out_ff.pair_valid;
   assign rsp_word0      = out_ff.word0;
   assign rsp_word1      = out_ff.word1;
   assign rsp_is_control = out_ff.is_control;
   assign rsp_mem_read   = out_ff.mem_read;
   assign rsp_read_addr  = out_ff.read_addr;

   // an accepted transfer is held in the input register next cycle
   a_take_holds: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_vld_ff)
      else $error("accepted transfer lost from input register");

   // a blocked item stays in the input register unchanged
   a_block_holds: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !adv) |=> (in_vld_ff && $stable(in_op_ff) && $stable(in_chan_ff)))
      else $error("blocked item changed");

   // without a memory read no address is reported
   a_no_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_mem_read) |-> (rsp_read_addr == 32'd0))
      else $error("read address without memory read");

   // a valid pair without a fetch only comes from an absent channel
   a_absent_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pair_valid && !rsp_mem_read)
         |-> (rsp_word0 == 16'd0 && rsp_word1 == 16'd0 && rsp_is_control))
      else $error("pair without fetch has payload");

endmodule
`default_nettype wire

// File: hw/rtl/spr_dma_chan_file.sv
`default_nettype none
// ---------------------------------------------------------------------------
// spr_dma_chan_file
// per-channel context registers, one write port and a frame restart
// ---------------------------------------------------------------------------
module spr_dma_chan_file (
   input  wire                               clock,
   input  wire                               reset,
   input  wire  [spr_dma_pkg::CH_IDX_W-1:0]  rd_idx,
   output spr_dma_pkg::chan_state_type       rd_state,
   input  wire                               upd_en,
   input  spr_dma_pkg::chan_upd_type         upd
);
   import spr_dma_pkg::*;

   chan_state_type st_ff [CHANNELS];

   assign rd_state = st_ff[rd_idx];

   always_ff @(posedge clock) begin
      for (int i = 0; i < CHANNELS; i++) begin
         if (reset) begin
            st_ff[i] <= '{list_base: '0, fetch_ptr: '0, armed: 1'b0, terminated: 1'b0,
                          ctrl_next: 1'b1, start_line: '0, stop_line: '0,
                          first_word: '0};
         end else if (upd_en && upd.frame) begin
            // restart every channel from its base pointer
            st_ff[i].fetch_ptr  <= st_ff[i].list_base;
            st_ff[i].armed      <= 1'b0;
            st_ff[i].terminated <= 1'b0;
            st_ff[i].ctrl_next  <= 1'b1;
            st_ff[i].start_line <= '0;
            st_ff[i].stop_line  <= '0;
            st_ff[i].first_word <= '0;
         end else if (upd_en && upd.wr && (rd_idx == CH_IDX_W'(i))) begin
            st_ff[i] <= upd.st;
         end
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/spr_dma_slot.sv
`default_nettype none
// ---------------------------------------------------------------------------
// spr_dma_slot
// decodes one operation against the addressed channel's context
// ---------------------------------------------------------------------------
module spr_dma_slot (
   input  wire  [2:0]                    operation,
   input  wire  [2:0]                    channel,
   input  wire  [15:0]                   vpos,
   input  wire  [15:0]                   write_value,
   input  wire  [15:0]                   mem_word,
   input  spr_dma_pkg::chan_state_type   cur,
   output spr_dma_pkg::chan_upd_type     upd,
   output spr_dma_pkg::rsp_type          rsp
);
   import spr_dma_pkg::*;

   logic chan_ok;
   logic skip;

   assign chan_ok = ({1'b0, channel} < 4'(CHANNELS));
   assign skip    = cur.terminated || (cur.armed && (vpos < {7'b0, cur.start_line}));

   always_comb begin
      upd     = '0;
      upd.st  = cur;
      rsp     = '0;
      unique case (operation)
         OP_PTR_HI, OP_PTR_LO: begin
            if (chan_ok) begin
               if (operation == OP_PTR_HI) begin
                  upd.st.list_base = {write_value, cur.list_base[15:0]};
               end else begin
                  upd.st.list_base = {cur.list_base[31:16], write_value};
               end
               upd.st.fetch_ptr  = upd.st.list_base;
               upd.st.armed      = 1'b0;
               upd.st.terminated = 1'b0;
               upd.st.ctrl_next  = 1'b1;
               upd.wr            = 1'b1;
            end
         end
         OP_FRAME: begin
            upd.frame = 1'b1;
         end
         OP_SLOT_A, OP_SLOT_B: begin
            if (!chan_ok) begin
               if (operation == OP_SLOT_B) begin
                  rsp.pair_valid = 1'b1;
                  rsp.is_control = 1'b1;
               end
            end else if (!skip) begin
               rsp.mem_read     = 1'b1;
               rsp.read_addr    = cur.fetch_ptr;
               upd.st.fetch_ptr = cur.fetch_ptr + PTR_STEP;
               upd.wr           = 1'b1;
               if (operation == OP_SLOT_A) begin
                  upd.st.ctrl_next  = !cur.armed || (vpos >= {7'b0, cur.stop_line});
                  upd.st.first_word = mem_word;
               end else begin
                  rsp.word0      = cur.first_word;
                  rsp.word1      = mem_word;
                  rsp.is_control = cur.ctrl_next;
                  rsp.pair_valid = 1'b1;
                  if (cur.ctrl_next) begin
                     if ((cur.first_word == 16'd0) && (mem_word == 16'd0)) begin
                        // end-of-list marker
                        upd.st.armed      = 1'b0;
                        upd.st.terminated = 1'b1;
                        upd.st.ctrl_next  = 1'b1;
                        rsp.pair_valid    = 1'b0;
                     end else begin
                        upd.st.start_line = {mem_word[2], cur.first_word[15:8]};
                        upd.st.stop_line  = {mem_word[1], mem_word[15:8]};
                        upd.st.armed      = 1'b1;
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

// File: tb/sv/tb_sprite_dma_channel_sequencer.sv
// ---------------------------------------------------------------------------
// tb_sprite_dma_channel_sequencer
// self-checking bench for the eight-channel sprite dma sequencer: directed
// pointer, termination, data pair and frame cases, then random sprite lists
// built from the bench's own channel model, with random gaps on both sides
// and one long result hold-off that backs the pipeline up into the request side
// ---------------------------------------------------------------------------
module tb_sprite_dma_channel_sequencer;
   import spr_dma_pkg::*;

   // codes the block must ignore
   localparam logic [2:0] OP_RSVD_5 = 3'd5;
   localparam logic [2:0] OP_RSVD_6 = 3'd6;
   localparam logic [2:0] OP_RSVD_7 = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_operation;
   logic [2:0]  req_channel;
   logic [15:0] req_vpos;
   logic [15:0] req_write_value;
   logic [15:0] req_mem_word;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_pair_valid;
   logic [15:0] rsp_word0;
   logic [15:0] rsp_word1;
   logic        rsp_is_control;
   logic        rsp_mem_read;
   logic [31:0] rsp_read_addr;

   // bench copy of every channel context, advanced at each request transfer
   chan_state_type chan_ctx [CHANNELS];
   // responses predicted but not yet seen, oldest first
   rsp_type        awaited_responses [$];

   int error_count    = 0;
   int items_sent     = 0;
   bit idling_on      = 1'b1;
   int holdoff_cycles = 0;

   sprite_dma_channel_sequencer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_channel     (req_channel),
      .req_vpos        (req_vpos),
      .req_write_value (req_write_value),
      .req_mem_word    (req_mem_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pair_valid  (rsp_pair_valid),
      .rsp_word0       (rsp_word0),
      .rsp_word1       (rsp_word1),
      .rsp_is_control  (rsp_is_control),
      .rsp_mem_read    (rsp_mem_read),
      .rsp_read_addr   (rsp_read_addr)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #3000000;
      $display("TEST FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // channel model
   // ------------------------------------------------------------------------

   // pointer write or frame start: fetch restarts at the base, control first
   function automatic void rearm_channel(input int ch);
      chan_ctx[ch].fetch_ptr  = chan_ctx[ch].list_base;
      chan_ctx[ch].armed      = 1'b0;
      chan_ctx[ch].terminated = 1'b0;
      chan_ctx[ch].ctrl_next  = 1'b1;
   endfunction

   // advances the model by one request and returns the response it causes
   function automatic rsp_type compute_dma_response(input logic [2:0] op,
         input logic [2:0] ch, input logic [15:0] vpos, input logic [15:0] wv,
         input logic [15:0] mw);
      rsp_type r;
      int      k;
      r = '0;
      case (op)
         OP_PTR_HI, OP_PTR_LO: begin
            if (ch < CHANNELS) begin
               if (op == OP_PTR_HI) chan_ctx[ch].list_base[31:16] = wv;
               else chan_ctx[ch].list_base[15:0] = wv;
               rearm_channel(ch);
            end
         end
         OP_FRAME: begin
            // channel field is don't-care, every channel restarts
            for (k = 0; k < CHANNELS; k++) begin
               rearm_channel(k);
               chan_ctx[k].start_line = '0;
               chan_ctx[k].stop_line  = '0;
               chan_ctx[k].first_word = '0;
            end
         end
         OP_SLOT_A, OP_SLOT_B: begin
            if (ch >= CHANNELS) begin
               if (op == OP_SLOT_B) begin
                  r.pair_valid = 1'b1;
                  r.is_control = 1'b1;
               end
            end else if (!chan_ctx[ch].terminated &&
                  !(chan_ctx[ch].armed && vpos < chan_ctx[ch].start_line)) begin
               r.mem_read  = 1'b1;
               r.read_addr = chan_ctx[ch].fetch_ptr;
               chan_ctx[ch].fetch_ptr = chan_ctx[ch].fetch_ptr + PTR_STEP;
               if (op == OP_SLOT_A) begin
                  chan_ctx[ch].ctrl_next = !chan_ctx[ch].armed ||
                        vpos >= chan_ctx[ch].stop_line;
                  chan_ctx[ch].first_word = mw;
               end else begin
                  r.word0      = chan_ctx[ch].first_word;
                  r.word1      = mw;
                  r.is_control = chan_ctx[ch].ctrl_next;
                  r.pair_valid = 1'b1;
                  if (chan_ctx[ch].ctrl_next) begin
                     if (chan_ctx[ch].first_word == 16'h0000 && mw == 16'h0000) begin
                        // end-of-list marker
                        chan_ctx[ch].armed      = 1'b0;
                        chan_ctx[ch].terminated = 1'b1;
                        r.pair_valid            = 1'b0;
                     end else begin
                        chan_ctx[ch].start_line = {mw[2], chan_ctx[ch].first_word[15:8]};
                        chan_ctx[ch].stop_line  = {mw[1], mw[15:8]};
                        chan_ctx[ch].armed      = 1'b1;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   // one request transfer; valid stays high afterwards unless the next call idles
   task automatic send_item(input logic [2:0] op, input logic [2:0] ch,
         input logic [15:0] vpos, input logic [15:0] wv, input logic [15:0] mw);
      if (idling_on && $urandom_range(0, 99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_channel     <= ch;
      req_vpos        <= vpos;
      req_write_value <= wv;
      req_mem_word    <= mw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      awaited_responses.push_back(compute_dma_response(op, ch, vpos, wv, mw));
      items_sent++;
   endtask

   // any code, any field values
   task automatic send_noise_item();
      send_item(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
            16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // a/b slot pair whose words make sense for what the channel expects next
   task automatic send_slot_pair(input logic [2:0] ch, input logic [15:0] vpos);
      logic [8:0]  start_ln;
      logic [8:0]  stop_ln;
      logic [15:0] w0;
      logic [15:0] w1;
      w0 = 16'($urandom);
      w1 = 16'($urandom);
      if (!chan_ctx[ch].armed || vpos >= chan_ctx[ch].stop_line) begin
         if ($urandom_range(0, 99) < 12) begin
            w0 = 16'h0000;
            w1 = 16'h0000;
         end else begin
            start_ln = vpos[8:0] + 9'($urandom_range(0, 5));
            stop_ln  = start_ln + 9'($urandom_range(1, 12));
            w0 = {start_ln[7:0], 8'($urandom)};
            w1 = {stop_ln[7:0], 5'($urandom), start_ln[8], stop_ln[8], 1'($urandom)};
         end
      end
      send_item(OP_SLOT_A, ch, vpos, 16'h0000, w0);
      send_item(OP_SLOT_B, ch, vpos, 16'h0000, w1);
   endtask

   // random sprite lists: sometimes start a frame, repoint some channels, then walk the beam down
   // the screen with slot pairs, a little noise and some unpaired slots
   task automatic run_sprite_frames(input int item_budget);
      int          first_item;
      int unsigned pick;
      logic [2:0]  ch;
      logic [15:0] line;
      first_item = items_sent;
      while (items_sent - first_item < item_budget) begin
         if ($urandom_range(0, 3) == 0)
            send_item(OP_FRAME, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         repeat ($urandom_range(1, 4)) begin
            ch = 3'($urandom);
            send_item(OP_PTR_HI, ch, 16'($urandom), 16'($urandom), 16'($urandom));
            send_item(OP_PTR_LO, ch, 16'($urandom), 16'($urandom), 16'($urandom));
         end
         line = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(230, 490))
                                            : 16'($urandom_range(0, 60));
         repeat ($urandom_range(10, 40)) begin
            pick = $urandom_range(0, 99);
            ch   = 3'($urandom);
            if (pick < 85) send_slot_pair(ch, line);
            else if (pick < 92) send_noise_item();
            else send_item(($urandom_range(0, 1) == 0) ? OP_SLOT_A : OP_SLOT_B, ch, line,
                  16'($urandom), 16'($urandom));
            if ($urandom_range(0, 99) < 60) line++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------------

   // receiver stall: random gaps, or a long hold-off when a test asks for one
   initial begin : rsp_stall_driver
      int hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && holdoff_cycles != 0) begin
            hold_left      = holdoff_cycles;
            holdoff_cycles = 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= idling_on && $urandom_range(0, 99) < 6;
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         error_count++;
      end
   endtask

   // every result transfer against the oldest prediction
   initial begin : response_checker
      rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (awaited_responses.size() == 0) begin
               $error("response transfer with nothing outstanding");
               error_count++;
            end else begin
               want = awaited_responses.pop_front();
               check_field("pair_valid", 32'(want.pair_valid), 32'(rsp_pair_valid));
               check_field("word0", 32'(want.word0), 32'(rsp_word0));
               check_field("word1", 32'(want.word1), 32'(rsp_word1));
               check_field("is_control", 32'(want.is_control), 32'(rsp_is_control));
               check_field("mem_read", 32'(want.mem_read), 32'(rsp_mem_read));
               check_field("read_addr", want.read_addr, rsp_read_addr);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // top of the address space: fetch pointer wraps, nine-bit lines from the
   // control words, slot skipped below start, end-of-list marker terminates
   task automatic test_pointer_wrap();
      send_item(OP_PTR_HI, 3'd7, 16'h0000, 16'hFFFF, 16'h0000);
      send_item(OP_PTR_LO, 3'd7, 16'h0000, 16'hFFFE, 16'h0000);
      send_item(OP_SLOT_A, 3'd7, 16'h0000, 16'h0000, 16'hFFFF);
      send_item(OP_SLOT_B, 3'd7, 16'h0000, 16'h0000, 16'h0006);
      send_item(OP_SLOT_A, 3'd7, 16'h01FE, 16'h0000, 16'h1234);
      send_item(OP_SLOT_A, 3'd7, 16'hFFFF, 16'h0000, 16'h0000);
      send_item(OP_SLOT_B, 3'd7, 16'hFFFF, 16'h0000, 16'h0000);
      send_item(OP_SLOT_A, 3'd7, 16'hFFFF, 16'h0000, 16'h5A5A);
      send_item(OP_SLOT_B, 3'd7, 16'hFFFF, 16'h0000, 16'hA5A5);
   endtask

   // image data between start and stop, b-slot without a-slot, back to control
   task automatic test_data_pairs();
      send_item(OP_PTR_LO, 3'd0, 16'h0000, 16'h1000, 16'h0000);
      send_item(OP_SLOT_A, 3'd0, 16'd3, 16'h0000, 16'h0A5A);
      send_item(OP_SLOT_B, 3'd0, 16'd3, 16'h0000, 16'h1400);
      send_item(OP_SLOT_A, 3'd0, 16'd9, 16'h0000, 16'h7777);
      send_item(OP_SLOT_A, 3'd0, 16'd10, 16'h0000, 16'hAAAA);
      send_item(OP_SLOT_B, 3'd0, 16'd10, 16'h0000, 16'h5555);
      send_item(OP_SLOT_B, 3'd0, 16'd11, 16'h0000, 16'hFFFF);
      send_item(OP_SLOT_A, 3'd0, 16'd20, 16'h0000, 16'h0000);
      send_item(OP_SLOT_B, 3'd0, 16'd20, 16'h0000, 16'h0001);
   endtask

   // unused codes do nothing, frame start revives the terminated channel
   task automatic test_frame_and_unknown();
      send_item(OP_RSVD_5, 3'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(OP_RSVD_6, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(OP_RSVD_7, 3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(OP_FRAME, 3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(OP_SLOT_A, 3'd7, 16'h0000, 16'h0000, 16'h1234);
      send_item(OP_SLOT_B, 3'd7, 16'h0000, 16'h0000, 16'h5678);
   endtask

   task automatic test_random_frames();
      run_sprite_frames(820);
   endtask

   // back-to-back transfers, no gaps on either side
   task automatic test_no_idle_stretch();
      idling_on = 1'b0;
      run_sprite_frames(200);
      idling_on = 1'b1;
   endtask

   // results held off long enough that the request side must stall
   task automatic test_receiver_holdoff();
      holdoff_cycles = 80;
      run_sprite_frames(60);
   endtask

   task automatic test_random_noise();
      repeat (150) send_noise_item();
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      int k;
      for (k = 0; k < CHANNELS; k++) begin
         chan_ctx[k]           = '0;
         chan_ctx[k].ctrl_next = 1'b1;
      end
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_operation   <= OP_PTR_HI;
      req_channel     <= '0;
      req_vpos        <= '0;
      req_write_value <= '0;
      req_mem_word    <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_pointer_wrap();
      test_data_pairs();
      test_frame_and_unknown();
      test_random_frames();
      test_no_idle_stretch();
      test_receiver_holdoff();
      test_random_noise();
      req_valid <= 1'b0;

      // drain, then wait on to catch stray results
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
